// ===== rtl/trajectory_predictor_error_tracker_core_defines.svh =====
// Assertion helpers for the error tracker core.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef TRAJECTORY_PREDICTOR_ERROR_TRACKER_CORE_DEFINES_SVH
`define TRAJECTORY_PREDICTOR_ERROR_TRACKER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define TPET_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define TPET_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tpet_pkg.sv =====
`default_nettype none
package tpet_pkg;

  // Field and state widths
  localparam int LON_W         = 32;
  localparam int LAT_W         = 31;
  localparam int HIST_W        = 32;
  localparam int PRED_W        = 36;
  localparam int DIFF_W        = 37;
  localparam int ERR_W         = 32;
  localparam int SUM_BITS      = 48;
  localparam int SUM_OUT_W     = 48;
  localparam int STEP_W        = 32;
  localparam int SEEN_W        = 3;
  localparam int HISTORY_DEPTH = 6;
  localparam int N_PRED        = 4;

  // Stream widths
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 352;
  localparam int OUT_USER_W = 4;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Square-root unit: 64-bit radicand, one root bit per cycle
  localparam int RAD_W      = 64;
  localparam int ROOT_W     = 32;
  localparam int ROOT_CNT_W = $clog2(ROOT_W);
  localparam int REM_W      = ROOT_W + 2;

  // Small-constant divider: reciprocal multiply in two partial products
  localparam int DIV_W    = 35;
  localparam int DEN_W    = 3;
  localparam int RCP_W    = 37;
  localparam int RCP_LO_W = 19;
  localparam int RCP_K    = 38;
  localparam int DACC_W   = DIV_W + RCP_W + 1;

  localparam logic [DEN_W-1:0] DEN_3 = 3'd3;
  localparam logic [DEN_W-1:0] DEN_4 = 3'd4;
  localparam logic [DEN_W-1:0] DEN_5 = 3'd5;

  // Rounded-up reciprocals scaled by 2^RCP_K
  localparam logic [RCP_W-1:0] RCP_3 = 37'd91625968982;
  localparam logic [RCP_W-1:0] RCP_4 = 37'd68719476736;
  localparam logic [RCP_W-1:0] RCP_5 = 37'd54975581389;

  // Point-count thresholds
  localparam logic [SEEN_W-1:0] SEEN_LIN  = 3'd3;
  localparam logic [SEEN_W-1:0] SEEN_CUB  = 3'd4;
  localparam logic [SEEN_W-1:0] SEEN_SMO  = 3'd5;
  localparam logic [SEEN_W-1:0] SEEN_FULL = 3'd6;
  localparam logic [SEEN_W-1:0] SEEN_MAX  = 3'd7;

  // Predictor indexes
  localparam logic [1:0] PR_LIN  = 2'd0;
  localparam logic [1:0] PR_QUAD = 2'd1;
  localparam logic [1:0] PR_CUB  = 2'd2;
  localparam logic [1:0] PR_SMO  = 2'd3;

  // Division slots for the smoothed predictor
  localparam logic [1:0] DV_V_LON = 2'd0;
  localparam logic [1:0] DV_A_LON = 2'd1;
  localparam logic [1:0] DV_V_LAT = 2'd2;
  localparam logic [1:0] DV_A_LAT = 2'd3;

  // One classified point
  typedef struct packed {
    logic [LON_W-1:0]  lon;
    logic [LAT_W-1:0]  lat;
    logic [N_PRED-1:0] valid;
    logic [SEEN_W-1:0] seen;
  } item_t;

  // Queue head toward the back part
  typedef struct packed {
    logic  valid;
    item_t item;
  } qif_t;

  typedef struct packed {
    logic             start;
    logic [RAD_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_ADD,
    ST_ROOT,
    ST_ACC,
    ST_SHIFT,
    ST_PRED,
    ST_DIVGO,
    ST_DIVWAIT,
    ST_SMOOTH,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/tpet_front.sv =====
`default_nettype none
module tpet_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [tpet_pkg::LON_W-1:0]    in_lon,
  input  logic [tpet_pkg::LAT_W-1:0]    in_lat,
  output tpet_pkg::qif_t                q_out,
  input  logic                          q_pop
);

  tpet_pkg::item_t mem_r [tpet_pkg::Q_DEPTH];
  tpet_pkg::item_t new_item;
  logic [tpet_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [tpet_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [tpet_pkg::Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [tpet_pkg::SEEN_W-1:0]  seen_r, seen_nxt;
  logic                         push;
  logic                         pop;

  assign in_tready = (cnt_r != tpet_pkg::Q_CNT_W'(tpet_pkg::Q_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && (cnt_r != '0);

  // Classify the request: which errors are due, and the point count after it
  always_comb begin
    new_item.lon   = in_lon;
    new_item.lat   = in_lat;
    new_item.valid = {seen_r >= tpet_pkg::SEEN_SMO, seen_r >= tpet_pkg::SEEN_CUB,
                      seen_r >= tpet_pkg::SEEN_LIN, seen_r >= tpet_pkg::SEEN_LIN};
    new_item.seen  = (seen_r == tpet_pkg::SEEN_MAX) ? seen_r : seen_r + 1'b1;
  end

  // Advance pointers, count and point tally
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    seen_nxt   = seen_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == tpet_pkg::Q_PTR_W'(tpet_pkg::Q_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
      seen_nxt   = new_item.seen;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == tpet_pkg::Q_PTR_W'(tpet_pkg::Q_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      seen_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      seen_r   <= seen_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

  assign q_out.valid = (cnt_r != '0);
  assign q_out.item  = mem_r[rd_ptr_r];

endmodule
`default_nettype wire

// ===== rtl/tpet_isqrt.sv =====
`default_nettype none
module tpet_isqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  tpet_pkg::sqrt_req_t req,
  output tpet_pkg::sqrt_rsp_t rsp
);

  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;
  logic [tpet_pkg::ROOT_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [tpet_pkg::RAD_W-1:0]       rad_r, rad_nxt;
  logic [tpet_pkg::REM_W-1:0]       rem_r, rem_nxt;
  logic [tpet_pkg::ROOT_W-1:0]      root_r, root_nxt;
  logic [tpet_pkg::REM_W+1:0]       rem_t;
  logic [tpet_pkg::REM_W+1:0]       trial;
  logic [tpet_pkg::REM_W+1:0]       diff;
  logic                             ge;

  // One root bit per step: bring down two radicand bits, try 4r+1
  always_comb begin
    rem_t = {rem_r, rad_r[tpet_pkg::RAD_W-1 -: 2]};
    trial = {2'b00, root_r, 2'b01};
    ge    = (rem_t >= trial);
    diff  = rem_t - trial;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rad_nxt  = req.radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[tpet_pkg::REM_W-1:0] : rem_t[tpet_pkg::REM_W-1:0];
      root_nxt = {root_r[tpet_pkg::ROOT_W-2:0], ge};
      rad_nxt  = {rad_r[tpet_pkg::RAD_W-3:0], 2'b00};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == tpet_pkg::ROOT_CNT_W'(tpet_pkg::ROOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule
`default_nettype wire

// ===== rtl/tpet_cdiv.sv =====
`default_nettype none
module tpet_cdiv (
  input  logic               clk,
  input  logic               rst_n,
  input  tpet_pkg::div_req_t req,
  output tpet_pkg::div_rsp_t rsp
);

  logic                                        busy_r, busy_nxt;
  logic                                        ph_r, ph_nxt;
  logic                                        done_r, done_nxt;
  logic [tpet_pkg::DIV_W-1:0]                  mag_r, mag_nxt;
  logic [tpet_pkg::RCP_W-1:0]                  rcp_r, rcp_nxt;
  logic [tpet_pkg::DACC_W-1:0]                 acc_r, acc_nxt;
  logic                                        neg_r, neg_nxt;
  logic [tpet_pkg::RCP_W-1:0]                  rcp_sel;
  logic [tpet_pkg::RCP_LO_W-1:0]               mul_b;
  logic [tpet_pkg::DIV_W+tpet_pkg::RCP_LO_W-1:0] prod;
  logic [tpet_pkg::DIV_W-1:0]                  quot_mag;

  // Pick the scaled reciprocal of the divisor
  always_comb begin
    unique case (req.den)
      tpet_pkg::DEN_3: rcp_sel = tpet_pkg::RCP_3;
      tpet_pkg::DEN_5: rcp_sel = tpet_pkg::RCP_5;
      default:         rcp_sel = tpet_pkg::RCP_4;
    endcase
  end

  // One partial product per cycle: low reciprocal bits first, then high bits
  assign mul_b = ph_r ? tpet_pkg::RCP_LO_W'(rcp_r[tpet_pkg::RCP_W-1:tpet_pkg::RCP_LO_W])
                      : rcp_r[tpet_pkg::RCP_LO_W-1:0];
  assign prod  = mag_r * mul_b;

  // Multiply the magnitude, sign applied at the end (truncate toward zero)
  always_comb begin
    busy_nxt = busy_r;
    ph_nxt   = ph_r;
    done_nxt = 1'b0;
    mag_nxt  = mag_r;
    rcp_nxt  = rcp_r;
    acc_nxt  = acc_r;
    neg_nxt  = neg_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      ph_nxt   = 1'b0;
      neg_nxt  = req.num[tpet_pkg::DIV_W-1];
      mag_nxt  = req.num[tpet_pkg::DIV_W-1] ? (~req.num + 1'b1) : req.num;
      rcp_nxt  = rcp_sel;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (!ph_r) begin
        acc_nxt = tpet_pkg::DACC_W'(prod);
        ph_nxt  = 1'b1;
      end else begin
        acc_nxt  = acc_r + (tpet_pkg::DACC_W'(prod) << tpet_pkg::RCP_LO_W);
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    rcp_r <= rcp_nxt;
    acc_r <= acc_nxt;
    neg_r <= neg_nxt;
  end

  assign quot_mag = acc_r[tpet_pkg::RCP_K +: tpet_pkg::DIV_W];
  assign rsp.done = done_r;
  assign rsp.quot = neg_r ? (~quot_mag + 1'b1) : quot_mag;

endmodule
`default_nettype wire

// ===== rtl/tpet_back.sv =====
`default_nettype none
module tpet_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tpet_pkg::qif_t                    q_in,
  output logic                              q_pop,
  output tpet_pkg::sqrt_req_t               sqrt_req,
  input  tpet_pkg::sqrt_rsp_t               sqrt_rsp,
  output tpet_pkg::div_req_t                div_req,
  input  tpet_pkg::div_rsp_t                div_rsp,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tpet_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [tpet_pkg::OUT_USER_W-1:0]   out_tuser
);

  localparam int HD = tpet_pkg::HISTORY_DEPTH;
  localparam int NP = tpet_pkg::N_PRED;

  tpet_pkg::state_t state_r, state_nxt;
  tpet_pkg::item_t  cur_r, cur_nxt;

  logic signed [tpet_pkg::HIST_W-1:0] hist_lon_r [HD];
  logic signed [tpet_pkg::HIST_W-1:0] hist_lon_nxt [HD];
  logic signed [tpet_pkg::HIST_W-1:0] hist_lat_r [HD];
  logic signed [tpet_pkg::HIST_W-1:0] hist_lat_nxt [HD];
  logic signed [tpet_pkg::PRED_W-1:0] pred_lon_r [NP];
  logic signed [tpet_pkg::PRED_W-1:0] pred_lon_nxt [NP];
  logic signed [tpet_pkg::PRED_W-1:0] pred_lat_r [NP];
  logic signed [tpet_pkg::PRED_W-1:0] pred_lat_nxt [NP];
  logic [tpet_pkg::SUM_BITS-1:0]      sum_r [NP];
  logic [tpet_pkg::SUM_BITS-1:0]      sum_nxt [NP];
  logic [tpet_pkg::ERR_W-1:0]         err_r [NP];
  logic [tpet_pkg::ERR_W-1:0]         err_nxt [NP];
  logic signed [tpet_pkg::DIV_W-1:0]  vq_r [NP];
  logic signed [tpet_pkg::DIV_W-1:0]  vq_nxt [NP];
  logic [tpet_pkg::STEP_W-1:0]        steps_r, steps_nxt;
  logic [1:0]                         k_r, k_nxt;
  logic [1:0]                         dv_r, dv_nxt;
  logic [tpet_pkg::ERR_W-1:0]         dx_r, dx_nxt;
  logic [tpet_pkg::ERR_W-1:0]         dy_r, dy_nxt;
  logic [tpet_pkg::RAD_W-1:0]         sqx_r, sqx_nxt;
  logic [tpet_pkg::RAD_W-1:0]         sqy_r, sqy_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [tpet_pkg::OUT_DATA_W-1:0]    out_data_r, out_data_nxt;
  logic [tpet_pkg::OUT_USER_W-1:0]    out_user_r, out_user_nxt;

  logic signed [tpet_pkg::HIST_W-1:0] lon_c, lat_c;
  logic signed [tpet_pkg::DIFF_W-1:0] d_lon, d_lat;
  logic [tpet_pkg::DIFF_W-1:0]        m_lon, m_lat;
  logic                               dsat;
  logic [tpet_pkg::ERR_W-1:0]         mul_in;
  logic [tpet_pkg::RAD_W-1:0]         prod;
  logic [tpet_pkg::RAD_W:0]           sumsq;
  logic [tpet_pkg::SUM_BITS:0]        acc;
  logic signed [tpet_pkg::HIST_W-1:0] sel_h [HD];
  logic signed [tpet_pkg::DIV_W-1:0]  num_v, num_a;
  logic                               full;
  logic signed [tpet_pkg::PRED_W-1:0] e0, e1, e2, e3, f0, f1, f2, f3;

  function automatic logic signed [tpet_pkg::PRED_W-1:0] ext_p(
    input logic signed [tpet_pkg::HIST_W-1:0] x);
    ext_p = {{(tpet_pkg::PRED_W - tpet_pkg::HIST_W){x[tpet_pkg::HIST_W-1]}}, x};
  endfunction

  function automatic logic signed [tpet_pkg::DIV_W-1:0] ext_d(
    input logic signed [tpet_pkg::HIST_W-1:0] x);
    ext_d = {{(tpet_pkg::DIV_W - tpet_pkg::HIST_W){x[tpet_pkg::HIST_W-1]}}, x};
  endfunction

  function automatic logic signed [tpet_pkg::PRED_W-1:0] ext_q(
    input logic signed [tpet_pkg::DIV_W-1:0] x);
    ext_q = {{(tpet_pkg::PRED_W - tpet_pkg::DIV_W){x[tpet_pkg::DIV_W-1]}}, x};
  endfunction

  // Current point as 32-bit signed coordinates
  assign lon_c = cur_r.lon;
  assign lat_c = {cur_r.lat[tpet_pkg::LAT_W-1], cur_r.lat};

  // Difference to the selected prediction, magnitude and overflow
  always_comb begin
    d_lon = {{(tpet_pkg::DIFF_W - tpet_pkg::HIST_W){lon_c[tpet_pkg::HIST_W-1]}}, lon_c}
          - {pred_lon_r[k_r][tpet_pkg::PRED_W-1], pred_lon_r[k_r]};
    d_lat = {{(tpet_pkg::DIFF_W - tpet_pkg::HIST_W){lat_c[tpet_pkg::HIST_W-1]}}, lat_c}
          - {pred_lat_r[k_r][tpet_pkg::PRED_W-1], pred_lat_r[k_r]};
    m_lon = d_lon[tpet_pkg::DIFF_W-1] ? (~d_lon + 1'b1) : d_lon;
    m_lat = d_lat[tpet_pkg::DIFF_W-1] ? (~d_lat + 1'b1) : d_lat;
    dsat  = (|m_lon[tpet_pkg::DIFF_W-1:tpet_pkg::ERR_W]) ||
            (|m_lat[tpet_pkg::DIFF_W-1:tpet_pkg::ERR_W]);
  end

  // Shared squarer, one coordinate per cycle
  assign mul_in = (state_r == tpet_pkg::ST_SQX) ? dx_r : dy_r;
  assign prod   = mul_in * mul_in;
  assign sumsq  = {1'b0, sqx_r} + {1'b0, sqy_r};

  // Saturating accumulate of the current error
  assign acc = {1'b0, sum_r[k_r]} + (tpet_pkg::SUM_BITS + 1)'(err_r[k_r]);

  // Polynomial taps from the shifted history
  assign e0 = ext_p(hist_lon_r[0]);
  assign e1 = ext_p(hist_lon_r[1]);
  assign e2 = ext_p(hist_lon_r[2]);
  assign e3 = ext_p(hist_lon_r[3]);
  assign f0 = ext_p(hist_lat_r[0]);
  assign f1 = ext_p(hist_lat_r[1]);
  assign f2 = ext_p(hist_lat_r[2]);
  assign f3 = ext_p(hist_lat_r[3]);

  // Smoothed-predictor numerators for the coordinate in work
  assign full = (cur_r.seen >= tpet_pkg::SEEN_FULL);
  always_comb begin
    for (int i = 0; i < HD; i++) begin
      sel_h[i] = dv_r[1] ? hist_lat_r[i] : hist_lon_r[i];
    end
    num_v = full ? (ext_d(sel_h[0]) - ext_d(sel_h[5]))
                 : (ext_d(sel_h[0]) - ext_d(sel_h[4]));
    num_a = full ? ((ext_d(sel_h[0]) - ext_d(sel_h[1])) - (ext_d(sel_h[4]) - ext_d(sel_h[5])))
                 : ((ext_d(sel_h[0]) - ext_d(sel_h[1])) - (ext_d(sel_h[3]) - ext_d(sel_h[4])));
  end

  always_comb begin
    div_req.start = (state_r == tpet_pkg::ST_DIVGO);
    div_req.num   = dv_r[0] ? num_a : num_v;
    div_req.den   = dv_r[0] ? (full ? tpet_pkg::DEN_4 : tpet_pkg::DEN_3)
                            : (full ? tpet_pkg::DEN_5 : tpet_pkg::DEN_4);
    sqrt_req.start    = (state_r == tpet_pkg::ST_ADD) && !sumsq[tpet_pkg::RAD_W];
    sqrt_req.radicand = sumsq[tpet_pkg::RAD_W-1:0];
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    k_nxt         = k_r;
    dv_nxt        = dv_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    sqx_nxt       = sqx_r;
    sqy_nxt       = sqy_r;
    steps_nxt     = steps_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    q_pop         = 1'b0;
    for (int i = 0; i < HD; i++) begin
      hist_lon_nxt[i] = hist_lon_r[i];
      hist_lat_nxt[i] = hist_lat_r[i];
    end
    for (int i = 0; i < NP; i++) begin
      pred_lon_nxt[i] = pred_lon_r[i];
      pred_lat_nxt[i] = pred_lat_r[i];
      sum_nxt[i]      = sum_r[i];
      err_nxt[i]      = err_r[i];
      vq_nxt[i]       = vq_r[i];
    end

    // Drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      tpet_pkg::ST_IDLE: begin
        if (q_in.valid) begin
          q_pop     = 1'b1;
          cur_nxt   = q_in.item;
          k_nxt     = tpet_pkg::PR_LIN;
          state_nxt = tpet_pkg::ST_DIFF;
        end
      end
      tpet_pkg::ST_DIFF: begin
        dx_nxt = m_lon[tpet_pkg::ERR_W-1:0];
        dy_nxt = m_lat[tpet_pkg::ERR_W-1:0];
        if (!cur_r.valid[k_r]) begin
          err_nxt[k_r] = '0;
          state_nxt    = tpet_pkg::ST_ACC;
        end else if (dsat) begin
          err_nxt[k_r] = '1;
          state_nxt    = tpet_pkg::ST_ACC;
        end else begin
          state_nxt = tpet_pkg::ST_SQX;
        end
      end
      tpet_pkg::ST_SQX: begin
        sqx_nxt   = prod;
        state_nxt = tpet_pkg::ST_SQY;
      end
      tpet_pkg::ST_SQY: begin
        sqy_nxt   = prod;
        state_nxt = tpet_pkg::ST_ADD;
      end
      tpet_pkg::ST_ADD: begin
        // Sum of squares past 64 bits reads as the largest distance
        if (sumsq[tpet_pkg::RAD_W]) begin
          err_nxt[k_r] = '1;
          state_nxt    = tpet_pkg::ST_ACC;
        end else begin
          state_nxt = tpet_pkg::ST_ROOT;
        end
      end
      tpet_pkg::ST_ROOT: begin
        if (sqrt_rsp.done) begin
          err_nxt[k_r] = sqrt_rsp.root;
          state_nxt    = tpet_pkg::ST_ACC;
        end
      end
      tpet_pkg::ST_ACC: begin
        if (cur_r.valid[k_r]) begin
          sum_nxt[k_r] = acc[tpet_pkg::SUM_BITS] ? '1 : acc[tpet_pkg::SUM_BITS-1:0];
        end
        if (k_r == tpet_pkg::PR_SMO) begin
          state_nxt = tpet_pkg::ST_SHIFT;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = tpet_pkg::ST_DIFF;
        end
      end
      tpet_pkg::ST_SHIFT: begin
        for (int i = HD - 1; i > 0; i--) begin
          hist_lon_nxt[i] = hist_lon_r[i-1];
          hist_lat_nxt[i] = hist_lat_r[i-1];
        end
        hist_lon_nxt[0] = lon_c;
        hist_lat_nxt[0] = lat_c;
        if (cur_r.seen >= tpet_pkg::SEEN_LIN) begin
          if (steps_r != '1) begin
            steps_nxt = steps_r + 1'b1;
          end
          state_nxt = tpet_pkg::ST_PRED;
        end else begin
          state_nxt = tpet_pkg::ST_OUT;
        end
      end
      tpet_pkg::ST_PRED: begin
        pred_lon_nxt[tpet_pkg::PR_LIN]  = (e0 <<< 1) - e1;
        pred_lon_nxt[tpet_pkg::PR_QUAD] = ((e0 <<< 1) + e0) - ((e1 <<< 1) + e1) + e2;
        pred_lon_nxt[tpet_pkg::PR_CUB]  = (e0 <<< 2) - ((e1 <<< 2) + (e1 <<< 1))
                                        + (e2 <<< 2) - e3;
        pred_lat_nxt[tpet_pkg::PR_LIN]  = (f0 <<< 1) - f1;
        pred_lat_nxt[tpet_pkg::PR_QUAD] = ((f0 <<< 1) + f0) - ((f1 <<< 1) + f1) + f2;
        pred_lat_nxt[tpet_pkg::PR_CUB]  = (f0 <<< 2) - ((f1 <<< 2) + (f1 <<< 1))
                                        + (f2 <<< 2) - f3;
        if (cur_r.seen >= tpet_pkg::SEEN_SMO) begin
          dv_nxt    = tpet_pkg::DV_V_LON;
          state_nxt = tpet_pkg::ST_DIVGO;
        end else begin
          state_nxt = tpet_pkg::ST_OUT;
        end
      end
      tpet_pkg::ST_DIVGO: begin
        state_nxt = tpet_pkg::ST_DIVWAIT;
      end
      tpet_pkg::ST_DIVWAIT: begin
        if (div_rsp.done) begin
          vq_nxt[dv_r] = div_rsp.quot;
          if (dv_r == tpet_pkg::DV_A_LAT) begin
            state_nxt = tpet_pkg::ST_SMOOTH;
          end else begin
            dv_nxt    = dv_r + 1'b1;
            state_nxt = tpet_pkg::ST_DIVGO;
          end
        end
      end
      tpet_pkg::ST_SMOOTH: begin
        pred_lon_nxt[tpet_pkg::PR_SMO] = e0 + ext_q(vq_r[tpet_pkg::DV_V_LON])
                                       + ext_q(vq_r[tpet_pkg::DV_A_LON]);
        pred_lat_nxt[tpet_pkg::PR_SMO] = f0 + ext_q(vq_r[tpet_pkg::DV_V_LAT])
                                       + ext_q(vq_r[tpet_pkg::DV_A_LAT]);
        state_nxt = tpet_pkg::ST_OUT;
      end
      tpet_pkg::ST_OUT: begin
        // Load the result register once it is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {steps_r,
                           tpet_pkg::SUM_OUT_W'(sum_r[3]), tpet_pkg::SUM_OUT_W'(sum_r[2]),
                           tpet_pkg::SUM_OUT_W'(sum_r[1]), tpet_pkg::SUM_OUT_W'(sum_r[0]),
                           err_r[3], err_r[2], err_r[1], err_r[0]};
          out_user_nxt  = cur_r.valid;
          state_nxt     = tpet_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tpet_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tpet_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      steps_r     <= '0;
      for (int i = 0; i < HD; i++) begin
        hist_lon_r[i] <= '0;
        hist_lat_r[i] <= '0;
      end
      for (int i = 0; i < NP; i++) begin
        pred_lon_r[i] <= '0;
        pred_lat_r[i] <= '0;
        sum_r[i]      <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      steps_r     <= steps_nxt;
      for (int i = 0; i < HD; i++) begin
        hist_lon_r[i] <= hist_lon_nxt[i];
        hist_lat_r[i] <= hist_lat_nxt[i];
      end
      for (int i = 0; i < NP; i++) begin
        pred_lon_r[i] <= pred_lon_nxt[i];
        pred_lat_r[i] <= pred_lat_nxt[i];
        sum_r[i]      <= sum_nxt[i];
      end
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    k_r        <= k_nxt;
    dv_r       <= dv_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    sqx_r      <= sqx_nxt;
    sqy_r      <= sqy_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    for (int i = 0; i < NP; i++) begin
      err_r[i] <= err_nxt[i];
      vq_r[i]  <= vq_nxt[i];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire

// ===== rtl/trajectory_predictor_error_tracker_core.sv =====
// One point is in work at a time; each due error is taken through the square-root unit,
// one root bit per cycle, unless the distance saturates, and the smoothed predictor
// adds four reciprocal-multiply divisions and a step to combine them.
// A result held by out_tready stalls the back; a two-entry queue takes points meanwhile.
// Reset: synchronous, active low; clears history, predictions, sums, step count and queue.
`default_nettype none
`include "trajectory_predictor_error_tracker_core_defines.svh"
module trajectory_predictor_error_tracker_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // longitude[31:0], latitude[62:32], zero pad[63]
  input  logic [tpet_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // err_linear[31:0], err_quadratic[63:32], err_cubic[95:64], err_smoothed[127:96],
  // sum_linear[175:128], sum_quadratic[223:176], sum_cubic[271:224],
  // sum_smoothed[319:272], step_count[351:320]
  output logic [tpet_pkg::OUT_DATA_W-1:0]  out_tdata,
  // err_valid[3:0]
  output logic [tpet_pkg::OUT_USER_W-1:0]  out_tuser
);

  tpet_pkg::qif_t      q_head;
  logic                q_pop;
  tpet_pkg::sqrt_req_t sqrt_req;
  tpet_pkg::sqrt_rsp_t sqrt_rsp;
  tpet_pkg::div_req_t  div_req;
  tpet_pkg::div_rsp_t  div_rsp;

  // Accept and classify points
  tpet_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_lon    (in_tdata[tpet_pkg::LON_W-1:0]),
    .in_lat    (in_tdata[tpet_pkg::LON_W +: tpet_pkg::LAT_W]),
    .q_out     (q_head),
    .q_pop     (q_pop)
  );

  // Error, sums and next predictions
  tpet_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_in       (q_head),
    .q_pop      (q_pop),
    .sqrt_req   (sqrt_req),
    .sqrt_rsp   (sqrt_rsp),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  tpet_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .rsp   (sqrt_rsp)
  );

  tpet_cdiv u_cdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  `TPET_ASSERT_IMP(a_cubic_needs_linear, out_tvalid && out_tuser[2], out_tuser[0], "cubic error valid without linear")
  `TPET_ASSERT_IMP(a_missing_error_zero, out_tvalid && !out_tuser[0], out_tdata[31:0] == 32'd0, "linear error not zero when not due")
  `TPET_ASSERT_IMP(a_smooth_steps, out_tvalid && out_tuser[3], out_tdata[351:320] >= 32'd3, "smoothed error with too few steps")
  `TPET_ASSERT_NXT(a_queue_no_fill, in_tready && !in_tvalid, in_tready, "queue filled without a request")

endmodule
`default_nettype wire
